### hdl/nsrc_pkg.sv
// Package with the widths, register map and helper functions of the nearest sample rate converter.
`timescale 1ns / 1ps

package nsrc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 16;
  localparam int OCNT_W    = 24;
  localparam int FRAC_BITS = 8;
  localparam int MIN_STEP  = 4;
  localparam int MAX_OUT   = 64;
  localparam int NCNT_W    = $clog2(MAX_OUT + 1);
  localparam int RESET_STEP  = 256;
  localparam int BYTE_OFFSET = 128;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_STEP_RATIO   = 2'd0;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] REG_WIDE_SAMPLES = 2'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [OCNT_W-1:0]   ocnt_t;

  function automatic logic signed [SAMPLE_W-1:0] convert_sample(input sample_t raw,
                                                                input logic wide);
    logic signed [8:0] narrow;
    narrow = $signed({1'b0, raw[7:0]}) - 9'sd128;
    if (wide) begin
      return $signed(raw);
    end
    return SAMPLE_W'(narrow);
  endfunction

  function automatic step_t clamp_step(input step_t step);
    if (step < step_t'(MIN_STEP)) begin
      return step_t'(MIN_STEP);
    end
    return step;
  endfunction

endpackage

### hdl/nearest_sample_rate_converter_core.sv
// Top level of the nearest sample rate converter with its register port and output sequencer.
//
// The block takes one raw mono PCM sample per input beat (in_valid_i, in_ready_o) and
// delivers zero or more converted copies of it as output beats (out_valid_o, out_ready_i).
// Output position i takes source sample (i * step) >> 8, where step is the 8.8 ratio held
// in the step register; output_count bounds the outputs of one sound, and a beat with
// sound_start_i set clears the position, source index and output counters first.
// An accepted sample is checked in the next cycle by the add-and-compare logic, which
// then emits one copy per cycle while the output register is free, looking one position
// ahead to flag the last copy. An input beat occupies the block until its copies, at most 64,
// are issued; no new sample is accepted meanwhile. A finished result waits in the output
// register while the next sample is accepted. When the receiver stalls, the sequencer holds
// its position until the register frees. Reset sets step to 256, output_count and
// wide_samples to zero and clears all counters. Registers are written over the APB port at
// byte addresses 0, 4 and 8; the user must write them only while idle, unchecked by the block.
`timescale 1ns / 1ps

module nearest_sample_rate_converter_core #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nsrc_pkg::PADDR_W-1:0]         paddr,
  input  logic [nsrc_pkg::PDATA_W-1:0]         pwdata,
  output logic [nsrc_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [nsrc_pkg::SAMPLE_W-1:0]        raw_sample_i,
  input  logic                                 sound_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [nsrc_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                                 last_of_input_o,
  output logic                                 sound_done_o
);

  localparam int ACC_W = COUNT_BITS + nsrc_pkg::FRAC_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                          state_q, state_d;
  nsrc_pkg::step_t                 step_q;
  nsrc_pkg::ocnt_t                 ocnt_q;
  logic                            wide_q;
  logic [COUNT_BITS-1:0]           src_q, src_d;
  logic [ACC_W-1:0]                acc_q, acc_d;
  logic [COUNT_BITS-1:0]           em_q, em_d;
  logic [nsrc_pkg::NCNT_W-1:0]     n_q, n_d;
  logic signed [nsrc_pkg::SAMPLE_W-1:0] smp_q;
  logic                            out_valid_q, out_valid_d;
  logic signed [nsrc_pkg::SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic                            last_q, last_d;
  logic                            done_q, done_d;

  logic                            cfg_write;
  logic [1:0]                      reg_index;
  logic [31:0]                     ocnt_ext;
  logic [COUNT_BITS-1:0]           limit;
  logic [ACC_W-1:0]                acc_next;
  logic [COUNT_BITS-1:0]           em_inc;
  logic [nsrc_pkg::NCNT_W-1:0]     n_inc;
  logic                            cond;
  logic                            next_cond;
  logic                            slot_free;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_index = paddr[nsrc_pkg::PADDR_W-1:2];

  always_comb begin
    prdata = '0;
    case (reg_index)
      nsrc_pkg::REG_STEP_RATIO:   prdata = nsrc_pkg::PDATA_W'(step_q);
      nsrc_pkg::REG_OUTPUT_COUNT: prdata = nsrc_pkg::PDATA_W'(ocnt_q);
      nsrc_pkg::REG_WIDE_SAMPLES: prdata = nsrc_pkg::PDATA_W'(wide_q);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= nsrc_pkg::step_t'(nsrc_pkg::RESET_STEP);
      ocnt_q <= '0;
      wide_q <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        nsrc_pkg::REG_STEP_RATIO:   step_q <= pwdata[nsrc_pkg::STEP_W-1:0];
        nsrc_pkg::REG_OUTPUT_COUNT: ocnt_q <= pwdata[nsrc_pkg::OCNT_W-1:0];
        nsrc_pkg::REG_WIDE_SAMPLES: wide_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign ocnt_ext  = 32'(ocnt_q);
  assign limit     = ocnt_ext[COUNT_BITS-1:0];
  assign acc_next  = acc_q + ACC_W'(nsrc_pkg::clamp_step(step_q));
  assign em_inc    = em_q + 1'b1;
  assign n_inc     = n_q + 1'b1;
  assign cond      = (n_q < nsrc_pkg::NCNT_W'(nsrc_pkg::MAX_OUT)) && (em_q < limit) &&
                     (acc_q[ACC_W-1:nsrc_pkg::FRAC_BITS] == src_q);
  assign next_cond = (n_inc < nsrc_pkg::NCNT_W'(nsrc_pkg::MAX_OUT)) && (em_inc < limit) &&
                     (acc_next[ACC_W-1:nsrc_pkg::FRAC_BITS] == src_q);
  assign slot_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    src_d        = src_q;
    acc_d        = acc_q;
    em_d         = em_q;
    n_d          = n_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sample_d = out_sample_q;
    last_d       = last_q;
    done_d       = done_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          n_d     = '0;
          if (sound_start_i) begin
            src_d = '0;
            acc_d = '0;
            em_d  = '0;
          end
        end
      end
      ST_RUN: begin
        if (!cond) begin
          src_d   = src_q + 1'b1;
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_valid_d  = 1'b1;
          out_sample_d = smp_q;
          last_d       = !next_cond;
          done_d       = (em_inc == limit);
          acc_d        = acc_next;
          em_d         = em_inc;
          n_d          = n_inc;
          if (!next_cond) begin
            src_d   = src_q + 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_q       <= '0;
      acc_q       <= '0;
      em_q        <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      src_q       <= src_d;
      acc_q       <= acc_d;
      em_q        <= em_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= nsrc_pkg::convert_sample(raw_sample_i, wide_q);
    end
    out_sample_q <= out_sample_d;
    last_q       <= last_d;
    done_q       <= done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = out_sample_q;
  assign last_of_input_o = last_q;
  assign sound_done_o    = done_q;

endmodule
